/* src/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and tables for the character-LCD bus sequencer
// Request and transfer structs, opcode codes, init command tables and
// row base addresses.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // Request opcodes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_GLYPH  = 3'd4;

  // Bus modes
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_4BIT = 1'b1;

  // Index of the final byte of each init run
  localparam logic [3:0] INIT8_LAST = 4'd7;
  localparam logic [3:0] INIT4_LAST = 4'd8;

  localparam logic [7:0] GLYPH_BASE = 8'h40;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic [2:0] row;
    logic [5:0] column;
    logic [2:0] glyph_slot;
  } req_t;

  typedef struct packed {
    logic        register_select;
    logic [7:0]  bus_value;
    logic [14:0] wait_before_us;
    logic        last;
  } xfer_t;

  // Eight-line init commands
  function automatic logic [7:0] init8_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd3: c = 8'h38;
      4'd4:    c = 8'h08;
      4'd5:    c = 8'h01;
      4'd6:    c = 8'h06;
      4'd7:    c = 8'h0C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Four-line init commands
  function automatic logic [7:0] init4_cmd(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0, 4'd1, 4'd2: c = 8'h38;
      4'd3:    c = 8'h01;
      4'd4:    c = 8'h02;
      4'd5:    c = 8'h06;
      4'd6:    c = 8'h0C;
      4'd7:    c = 8'h28;
      4'd8:    c = 8'h80;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Power-up waits, shared by both modes
  function automatic logic [14:0] init_wait(input logic [3:0] idx);
    logic [14:0] w;
    case (idx)
      4'd0:    w = 15'd20000;
      4'd1:    w = 15'd5000;
      4'd2:    w = 15'd150;
      default: w = 15'd0;
    endcase
    return w;
  endfunction

  // DDRAM base address of a row (1 to 4)
  function automatic logic [7:0] row_base(input logic [2:0] row);
    logic [7:0] b;
    case (row)
      3'd1:    b = 8'h80;
      3'd2:    b = 8'hC0;
      3'd3:    b = 8'h94;
      3'd4:    b = 8'hD4;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/clcd_byte_unit.sv */
// ----------------------------------------------------------------------------
// clcd_byte_unit: byte builder for one step of a run
// Selects the operands for the request and the step index and forms the
// byte through one shared 8-bit adder.
// ----------------------------------------------------------------------------
module clcd_byte_unit (
  input  clcd_pkg::req_t req_i,
  input  logic           mode_i,
  input  logic [3:0]     idx_i,
  output logic [7:0]     byte_o
);

  logic [7:0] op_a;
  logic [7:0] op_b;
  logic [7:0] op_c;

  // Pick adder operands per opcode
  always_comb begin
    op_a = 8'h00;
    op_b = 8'h00;
    op_c = 8'h00;
    case (req_i.opcode)
      clcd_pkg::OP_INIT: begin
        op_a = (mode_i == clcd_pkg::MODE_4BIT) ? clcd_pkg::init4_cmd(idx_i)
                                               : clcd_pkg::init8_cmd(idx_i);
      end
      clcd_pkg::OP_CMD, clcd_pkg::OP_DATA: begin
        op_a = req_i.value;
      end
      clcd_pkg::OP_CURSOR: begin
        // base + column - 1, wrapping in eight bits
        op_a = clcd_pkg::row_base(req_i.row);
        op_b = {2'b00, req_i.column};
        op_c = 8'hFF;
      end
      clcd_pkg::OP_GLYPH: begin
        op_a = clcd_pkg::GLYPH_BASE;
        op_b = {2'b00, req_i.glyph_slot, 3'b000};
      end
      default: begin
        op_a = 8'h00;
      end
    endcase
  end

  // Shared adder
  assign byte_o = op_a + op_b + op_c;

endmodule

/* src/char_lcd_bus_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: character-LCD request to bus transfer sequencer
// Turns init, command, data, cursor and glyph-slot requests into runs of
// register-select / data / wait transfers in eight- or four-line mode.
// ----------------------------------------------------------------------------
//  channel   | signals                      | handshake
//  ----------+------------------------------+--------------------------------
//  request   | start_i, req_i, busy_o       | taken when start_i & !busy_o
//  transfer  | xfer_valid_o, xfer_o         | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_wdata_i        | bus_mode written when cfg_we_i
//
//  One transfer per cycle; one byte per step in eight-line mode, a nibble per
//  step in four-line mode. busy_o is high from the accepting edge to the last
//  step. Runs have 18 transfers for four-line init, 8 for eight-line init and
//  2 or 1 for single-byte requests. A request that sends nothing leaves busy_o
//  low. Results are registered, in the cycle after their step; no stall.
//  Reset clears the sequencer, the strobe and bus_mode (eight-line mode).
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  clcd_pkg::req_t        req_i,
  output logic                  busy_o,
  output logic                  xfer_valid_o,
  output clcd_pkg::xfer_t       xfer_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HI   = 3'b010,
    ST_LO   = 3'b100
  } state_e;

  state_e          state_q, state_d;
  clcd_pkg::req_t  req_q;
  logic            mode_q;
  logic            bus_mode_q;
  logic [3:0]      idx_q, idx_d;
  logic [3:0]      last_idx_q;
  logic            valid_q, valid_d;
  clcd_pkg::xfer_t xfer_q, xfer_d;

  logic            accept;
  logic            req_emits;
  logic [3:0]      req_last_idx;
  logic [7:0]      step_byte;
  logic            last_byte;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Decide whether a request sends anything and how many bytes it has
  always_comb begin
    req_emits    = 1'b1;
    req_last_idx = 4'd0;
    case (req_i.opcode)
      clcd_pkg::OP_INIT: begin
        req_last_idx = (bus_mode_q == clcd_pkg::MODE_4BIT) ? clcd_pkg::INIT4_LAST
                                                           : clcd_pkg::INIT8_LAST;
      end
      clcd_pkg::OP_CMD, clcd_pkg::OP_DATA, clcd_pkg::OP_GLYPH: begin
        req_emits = 1'b1;
      end
      clcd_pkg::OP_CURSOR: begin
        req_emits = (req_i.row inside {[3'd1:3'd4]});
      end
      default: begin
        req_emits = 1'b0;
      end
    endcase
  end

  clcd_byte_unit u_byte (
    .req_i  (req_q),
    .mode_i (mode_q),
    .idx_i  (idx_q),
    .byte_o (step_byte)
  );

  assign last_byte = (idx_q == last_idx_q);

  // Sequence the steps and build the next transfer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    valid_d = 1'b0;
    xfer_d  = xfer_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_emits) begin
          state_d = ST_HI;
          idx_d   = 4'd0;
        end
      end
      ST_HI: begin
        valid_d                = 1'b1;
        xfer_d.register_select = (req_q.opcode == clcd_pkg::OP_DATA);
        xfer_d.wait_before_us  = (req_q.opcode == clcd_pkg::OP_INIT) ?
                                 clcd_pkg::init_wait(idx_q) : 15'd0;
        if (mode_q == clcd_pkg::MODE_4BIT) begin
          xfer_d.bus_value = {4'h0, step_byte[7:4]};
          xfer_d.last      = 1'b0;
          state_d          = ST_LO;
        end else begin
          xfer_d.bus_value = step_byte;
          xfer_d.last      = last_byte;
          idx_d            = idx_q + 4'd1;
          state_d          = last_byte ? ST_IDLE : ST_HI;
        end
      end
      ST_LO: begin
        valid_d                = 1'b1;
        xfer_d.register_select = (req_q.opcode == clcd_pkg::OP_DATA);
        xfer_d.wait_before_us  = 15'd0;
        xfer_d.bus_value       = {4'h0, step_byte[3:0]};
        xfer_d.last            = last_byte;
        idx_d                  = idx_q + 4'd1;
        state_d                = last_byte ? ST_IDLE : ST_HI;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= 4'd0;
      valid_q    <= 1'b0;
      bus_mode_q <= clcd_pkg::MODE_8BIT;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        bus_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the request and the output transaction
  always_ff @(posedge clk_i) begin
    xfer_q <= xfer_d;
    if (accept) begin
      req_q      <= req_i;
      mode_q     <= bus_mode_q;
      last_idx_q <= req_last_idx;
    end
  end

  assign xfer_valid_o = valid_q;
  assign xfer_o       = xfer_q;

endmodule
